>>> rtl/bba_pkg.sv
// Package: constants, node codes and state types for the buddy allocator.
package bba_pkg;
   localparam int POOL_LOG2 = 12;
   localparam int MIN_LOG2 = 7;
   localparam int MIN_EFF = (MIN_LOG2 < POOL_LOG2) ? MIN_LOG2 : POOL_LOG2;
   localparam int DEPTHS = POOL_LOG2 - MIN_EFF + 1;
   localparam int NODES = (1 << DEPTHS) - 1;
   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int DEP_W = $clog2(DEPTHS + 1);

   typedef logic [1:0] node_type;
   localparam node_type ST_ABSENT = 2'd0;
   localparam node_type ST_FREE = 2'd1;
   localparam node_type ST_SPLIT = 2'd2;
   localparam node_type ST_ALLOC = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STS_OK = 2'd0;
   localparam status_type STS_NOBLK = 2'd1;
   localparam status_type STS_BIG = 2'd2;
   localparam status_type STS_BADOFF = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_CHK, S_SPLIT, S_FWALK, S_FCHK, S_BUD, S_BUD_CHK,
      S_MERGE, S_PARENT, S_DONE
   } fsm_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      node_type         wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;
endpackage

>>> rtl/bba_node_ram.sv
// Node state memory: one write and one registered read port, reset clearing pass.
module bba_node_ram (
   input  logic                     clock,
   input  logic                     reset,
   input  bba_pkg::mem_req_type     req,
   output bba_pkg::node_type        rdata,
   output logic                     ready
);
   bba_pkg::node_type mem [bba_pkg::NODES];
   logic [bba_pkg::IDX_W:0] clr_ff;
   logic [bba_pkg::IDX_W:0] clr_in;
   logic                    we;
   logic [bba_pkg::IDX_W-1:0] wa;
   bba_pkg::node_type         wd;

   assign ready = (clr_ff == (bba_pkg::IDX_W+1)'(bba_pkg::NODES));
   assign clr_in = ready ? clr_ff : clr_ff + 1'b1;

   always_comb begin
      if (!ready) begin
         we = 1'b1;
         wa = clr_ff[bba_pkg::IDX_W-1:0];
         wd = (clr_ff == '0) ? bba_pkg::ST_FREE : bba_pkg::ST_ABSENT;
      end else begin
         we = req.we;
         wa = req.waddr;
         wd = req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata <= mem[req.raddr];
   end
endmodule

>>> rtl/bba_ctrl.sv
// Sequencer: scan, split, free walk and merge over the node memory.
module bba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  logic [12:0]           req_request_size,
   input  logic [11:0]           req_free_offset,
   output logic                  rsp_valid,
   output logic [11:0]           rsp_block_offset,
   output logic [1:0]            rsp_status,
   output bba_pkg::mem_req_type  mreq,
   input  bba_pkg::node_type     rdata,
   input  logic                  mem_ready
);
   localparam int IW = bba_pkg::IDX_W;
   localparam int DW = bba_pkg::DEP_W;
   localparam int PL = bba_pkg::POOL_LOG2;

   bba_pkg::fsm_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] lim_ff, lim_in;
   logic [DW-1:0] dep_ff, dep_in;
   logic [DW-1:0] need_ff, need_in;
   logic [11:0]   off_ff, off_in;
   logic [1:0]    sts_ff, sts_in;
   logic          split2_ff, split2_in;
   logic          rv_ff, rv_in;

   logic [IW:0]   base_w, idx1, bud;
   logic [DW-1:0] need_c;
   logic [13:0]   sz;
   logic [IW-1:0] fidx;
   logic [PL:0]   koff;

   function automatic logic [IW-1:0] nbase(input logic [DW-1:0] d);
      nbase = IW'((1 << d) - 1);
   endfunction

   always_comb begin
      need_c = DW'(0);
      sz = {1'b0, req_request_size};
      for (int l = bba_pkg::POOL_LOG2; l >= bba_pkg::MIN_EFF; l--) begin
         if (sz <= 14'(1 << l)) begin
            need_c = DW'(PL - l);
         end
      end
   end

   always_comb begin
      fidx = nbase(dep_ff) + IW'(off_ff >> (PL - dep_ff));
   end

   assign idx1 = {1'b0, idx_ff} + 1'b1;
   assign bud = idx_ff[0] ? idx1 : ({1'b0, idx_ff} - 1'b1);
   assign base_w = {1'b0, nbase(dep_ff)};
   assign koff = (PL+1)'(({1'b0, idx_ff} - base_w)) << (PL - dep_ff);
   assign busy = (state_ff != bba_pkg::S_IDLE) || !mem_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::S_IDLE: if (start && !busy) begin
            if (req_action) state_in = bba_pkg::S_FWALK;
            else if (req_request_size > 13'(1 << PL)) state_in = bba_pkg::S_DONE;
            else state_in = bba_pkg::S_SCAN;
         end
         bba_pkg::S_SCAN: state_in = bba_pkg::S_SCAN_CHK;
         bba_pkg::S_SCAN_CHK: begin
            if (rdata == bba_pkg::ST_FREE) begin
               state_in = (dep_ff == need_ff) ? bba_pkg::S_DONE : bba_pkg::S_SPLIT;
            end else if (idx_ff == lim_ff && dep_ff == '0) begin
               state_in = bba_pkg::S_DONE;
            end else begin
               state_in = bba_pkg::S_SCAN_CHK;
            end
         end
         bba_pkg::S_SPLIT: if (dep_ff == need_ff && !split2_ff) state_in = bba_pkg::S_DONE;
         bba_pkg::S_FWALK: state_in = bba_pkg::S_FCHK;
         bba_pkg::S_FCHK: begin
            if (rdata == bba_pkg::ST_ALLOC) begin
               state_in = (koff == {1'b0, off_ff}) ? bba_pkg::S_BUD : bba_pkg::S_DONE;
            end else if (rdata == bba_pkg::ST_SPLIT && dep_ff != DW'(bba_pkg::DEPTHS - 1)) begin
               state_in = bba_pkg::S_FCHK;
            end else begin
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_BUD: state_in = (idx_ff == '0) ? bba_pkg::S_DONE : bba_pkg::S_BUD_CHK;
         bba_pkg::S_BUD_CHK: state_in = (rdata == bba_pkg::ST_FREE) ?
            bba_pkg::S_MERGE : bba_pkg::S_DONE;
         bba_pkg::S_MERGE: state_in = bba_pkg::S_PARENT;
         bba_pkg::S_PARENT: state_in = bba_pkg::S_BUD;
         bba_pkg::S_DONE: state_in = bba_pkg::S_IDLE;
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff; lim_in = lim_ff; dep_in = dep_ff; need_in = need_ff;
      off_in = off_ff; sts_in = sts_ff; split2_in = 1'b0;
      rv_in = (state_ff == bba_pkg::S_DONE);
      mreq = '0;
      mreq.raddr = idx_ff;
      case (state_ff)
         bba_pkg::S_IDLE: begin
            off_in = req_action ? req_free_offset : 12'd0;
            need_in = need_c;
            dep_in = req_action ? DW'(0) : need_c;
            idx_in = req_action ? IW'(0) : nbase(need_c);
            lim_in = req_action ? IW'(0) : IW'(2 * nbase(need_c));
            sts_in = (!req_action && req_request_size > 13'(1 << PL)) ?
               bba_pkg::STS_BIG : bba_pkg::STS_OK;
         end
         bba_pkg::S_SCAN: begin
            mreq.raddr = idx_ff;
            idx_in = idx_ff;
         end
         bba_pkg::S_SCAN_CHK: begin
            if (rdata == bba_pkg::ST_FREE) begin
               if (dep_ff == need_ff) begin
                  mreq.we = 1'b1; mreq.waddr = idx_ff; mreq.wdata = bba_pkg::ST_ALLOC;
                  off_in = koff[11:0];
               end else begin
                  mreq.we = 1'b1; mreq.waddr = idx_ff; mreq.wdata = bba_pkg::ST_SPLIT;
                  idx_in = IW'(2 * idx_ff + 1); split2_in = 1'b1;
               end
            end else if (idx_ff == lim_ff) begin
               if (dep_ff == '0) begin
                  sts_in = bba_pkg::STS_NOBLK;
               end else begin
                  dep_in = dep_ff - 1'b1;
                  idx_in = nbase(dep_ff - 1'b1);
                  lim_in = IW'(2 * nbase(dep_ff - 1'b1));
                  mreq.raddr = nbase(dep_ff - 1'b1);
               end
            end else begin
               idx_in = idx1[IW-1:0];
               mreq.raddr = idx1[IW-1:0];
            end
            if (!(rdata != bba_pkg::ST_FREE && idx_ff == lim_ff) && rdata != bba_pkg::ST_FREE)
               mreq.raddr = idx1[IW-1:0];
            if (rdata != bba_pkg::ST_FREE && idx_ff == lim_ff && dep_ff != '0)
               mreq.raddr = nbase(dep_ff - 1'b1);
         end
         bba_pkg::S_SPLIT: begin
            // idx_ff is the left child; write right child free first
            mreq.we = 1'b1;
            if (split2_ff) begin
               mreq.waddr = IW'(idx1); mreq.wdata = bba_pkg::ST_FREE;
               dep_in = dep_ff + 1'b1;
            end else if (dep_ff == need_ff) begin
               mreq.waddr = idx_ff; mreq.wdata = bba_pkg::ST_ALLOC;
               off_in = koff[11:0];
            end else begin
               mreq.waddr = idx_ff; mreq.wdata = bba_pkg::ST_SPLIT;
               idx_in = IW'(2 * idx_ff + 1); split2_in = 1'b1;
            end
         end
         bba_pkg::S_FWALK: begin
            mreq.raddr = fidx;
            idx_in = fidx;
         end
         bba_pkg::S_FCHK: begin
            if (rdata == bba_pkg::ST_ALLOC) begin
               if (state_in == bba_pkg::S_BUD) begin
                  mreq.we = 1'b1; mreq.waddr = idx_ff; mreq.wdata = bba_pkg::ST_FREE;
               end else begin
                  sts_in = bba_pkg::STS_BADOFF;
               end
            end else if (state_in == bba_pkg::S_FCHK) begin
               dep_in = dep_ff + 1'b1;
               idx_in = nbase(dep_ff + 1'b1) + IW'(off_ff >> (PL - dep_ff - 1));
               mreq.raddr = idx_in;
            end else begin
               sts_in = bba_pkg::STS_BADOFF;
            end
         end
         bba_pkg::S_BUD: begin
            mreq.raddr = IW'(bud);
         end
         bba_pkg::S_BUD_CHK: begin
            if (rdata == bba_pkg::ST_FREE) begin
               mreq.we = 1'b1; mreq.waddr = IW'(bud); mreq.wdata = bba_pkg::ST_ABSENT;
            end
         end
         bba_pkg::S_MERGE: begin
            mreq.we = 1'b1; mreq.waddr = idx_ff; mreq.wdata = bba_pkg::ST_ABSENT;
         end
         bba_pkg::S_PARENT: begin
            idx_in = IW'(({1'b0, idx_ff} - 1'b1) >> 1);
            mreq.we = 1'b1; mreq.waddr = idx_in; mreq.wdata = bba_pkg::ST_FREE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_IDLE;
         rv_ff <= 1'b0;
         split2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         split2_ff <= split2_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; lim_ff <= lim_in; dep_ff <= dep_in; need_ff <= need_in;
      off_ff <= off_in; sts_ff <= sts_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_block_offset = off_ff;
   assign rsp_status = sts_ff;
endmodule

>>> rtl/buddy_block_allocator.sv
// Top level of the binary buddy allocator.
// Binary buddy allocator over a 4096-byte pool with 128-byte smallest blocks
// (63 tree nodes in one synchronous RAM). Issue a transaction with start
// while busy is low; exactly one result appears later on rsp_ for one cycle
// with rsp_valid, and must be taken then. After acceptance busy stays high;
// the result is on rsp_ in the first cycle busy is low again, and the next
// transaction may be accepted at the end of that cycle. Allocation scans one
// node a cycle, needed level first, and splits a level by freeing the right
// child, then splitting or allocating the left; free walks down one level a
// cycle and merges each level through S_BUD, S_BUD_CHK, S_MERGE and S_PARENT.
// After reset busy stays high while the node RAM is cleared.
module buddy_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [12:0] req_request_size,
   input  logic [11:0] req_free_offset,
   output logic        rsp_valid,
   output logic [11:0] rsp_block_offset,
   output logic [1:0]  rsp_status
);
   bba_pkg::mem_req_type mreq;
   bba_pkg::node_type    rdata;
   logic                 mem_ready;

   bba_node_ram u_ram (
      .clock(clock), .reset(reset), .req(mreq), .rdata(rdata), .ready(mem_ready)
   );

   bba_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_request_size(req_request_size),
      .req_free_offset(req_free_offset), .rsp_valid(rsp_valid),
      .rsp_block_offset(rsp_block_offset), .rsp_status(rsp_status),
      .mreq(mreq), .rdata(rdata), .mem_ready(mem_ready)
   );
endmodule
